/* src/vn8_pkg.sv */
`default_nettype none

package vn8_pkg;

    // dimensions register
    localparam logic       REG_DIMENSIONS = 1'b0;
    localparam logic [1:0] DIMS_RESET     = 2'd3;
    localparam logic [1:0] DIMS_ONE       = 2'd1;
    localparam logic [1:0] DIMS_TWO       = 2'd2;

    typedef enum logic [1:0] {
        MODE_1D,
        MODE_2D,
        MODE_3D
    } vn_mode_t;

    // fixed permutation table
    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // 8x8 product, upper byte kept
    function automatic logic [7:0] mul_hi(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        begin
            p = 16'(a) * 16'(b);
            return p[15:8];
        end
    endfunction

    // 3*sq - 2*cu, clamped at 255
    function automatic logic [7:0] smooth_finish(input logic [7:0] sq, input logic [7:0] cu);
        logic [9:0] r;
        begin
            r = 10'(sq) + 10'({sq, 1'b0}) - 10'({cu, 1'b0});
            return (r > 10'd255) ? 8'hFF : r[7:0];
        end
    endfunction

    // 8-bit linear blend between a and b by t
    function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] t);
        logic [7:0] d;
        logic [7:0] s;
        begin
            d = (b >= a) ? (b - a) : (a - b);
            s = mul_hi(d, t);
            return (b >= a) ? (a + s) : (a - s);
        end
    endfunction

    // stage after first table read and squares
    typedef struct packed {
        vn_mode_t   mode;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] yi;
        logic [7:0] zi;
        logic [7:0] tx;
        logic [7:0] ty;
        logic [7:0] tz;
        logic [7:0] sqx;
        logic [7:0] sqy;
        logic [7:0] sqz;
    } vn_st1_t;

    // stage after second table read and cubes
    typedef struct packed {
        vn_mode_t   mode;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] zi;
        logic [7:0] ra;
        logic [7:0] ra1;
        logic [7:0] rb;
        logic [7:0] rb1;
        logic [7:0] sqx;
        logic [7:0] sqy;
        logic [7:0] sqz;
        logic [7:0] cux;
        logic [7:0] cuy;
        logic [7:0] cuz;
    } vn_st2_t;

    // corner pairs and weights
    typedef struct packed {
        vn_mode_t        mode;
        logic [3:0][7:0] lo;
        logic [3:0][7:0] hi;
        logic [7:0]      u;
        logic [7:0]      v;
        logic [7:0]      w;
    } vn_st3_t;

    typedef struct packed {
        vn_mode_t        mode;
        logic [3:0][7:0] xb;
        logic [7:0]      v;
        logic [7:0]      w;
    } vn_st4_t;

    typedef struct packed {
        vn_mode_t        mode;
        logic [1:0][7:0] yb;
        logic [7:0]      w;
    } vn_st5_t;

endpackage

`default_nettype wire

/* src/value_noise_8bit_unit.sv */
`default_nettype none

// 8-bit value noise in one, two or three dimensions. Each request carries three
// 16-bit coordinates (high byte lattice cell, low byte fraction) and yields one
// 8-bit sample. Six register stages: first table read and fraction squares,
// second hash read and cubes, third hash read and smoothstep, x blends, y blends,
// z blend into the output register. One request is taken every clock while the
// pipe flows, and a stall on the output side only holds up input once every
// stage is full. The dimensions register (byte address 0) picks 1, 2 or 3
// axes; a value of 0 acts as 3. It is sampled when a request enters, so writes
// should land while the unit is idle. pready is tied high and reads return the
// register.
module value_noise_8bit_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // noise_value [7:0]
);
    import vn8_pkg::*;

    // configuration
    logic [1:0] dims_reg;
    logic       cfg_wr;

    // stage valids, payloads
    logic    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    vn_st1_t st1_reg, st1_next;
    vn_st2_t st2_reg, st2_next;
    vn_st3_t st3_reg, st3_next;
    vn_st4_t st4_reg, st4_next;
    vn_st5_t st5_reg, st5_next;
    logic [7:0] out_reg, out_next;

    // per-stage load enables, collapsing bubbles
    logic en1, en2, en3, en4, en5, eno;

    logic [15:0] cx, cy, cz;

    assign cx = s_tdata[15:0];
    assign cy = s_tdata[31:16];
    assign cz = s_tdata[47:32];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIMENSIONS);
    assign prdata = (paddr[2] == REG_DIMENSIONS) ? {30'd0, dims_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_RESET;
        end
        else if (cfg_wr)
        begin
            dims_reg <= pwdata[1:0];
        end
    end

    // stall chain from the output register back to the input
    assign eno      = !vo_reg || m_tready;
    assign en5      = !v5_reg || eno;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: cell lookup along x, fraction squares
    always_comb
    begin
        case (dims_reg)
            DIMS_ONE: st1_next.mode = MODE_1D;
            DIMS_TWO: st1_next.mode = MODE_2D;
            default:  st1_next.mode = MODE_3D;
        endcase
        st1_next.p0  = PERM_ROM[cx[15:8]];
        st1_next.p1  = PERM_ROM[cx[15:8] + 8'd1];
        st1_next.yi  = cy[15:8];
        st1_next.zi  = cz[15:8];
        st1_next.tx  = cx[7:0];
        st1_next.ty  = cy[7:0];
        st1_next.tz  = cz[7:0];
        st1_next.sqx = mul_hi(cx[7:0], cx[7:0]);
        st1_next.sqy = mul_hi(cy[7:0], cy[7:0]);
        st1_next.sqz = mul_hi(cz[7:0], cz[7:0]);
    end

    // stage 2: hash in y, fraction cubes
    always_comb
    begin
        logic [7:0] a;
        logic [7:0] b;
        a = st1_reg.p0 + st1_reg.yi;
        b = st1_reg.p1 + st1_reg.yi;
        st2_next.mode = st1_reg.mode;
        st2_next.p0   = st1_reg.p0;
        st2_next.p1   = st1_reg.p1;
        st2_next.zi   = st1_reg.zi;
        st2_next.ra   = PERM_ROM[a];
        st2_next.ra1  = PERM_ROM[a + 8'd1];
        st2_next.rb   = PERM_ROM[b];
        st2_next.rb1  = PERM_ROM[b + 8'd1];
        st2_next.sqx  = st1_reg.sqx;
        st2_next.sqy  = st1_reg.sqy;
        st2_next.sqz  = st1_reg.sqz;
        st2_next.cux  = mul_hi(st1_reg.sqx, st1_reg.tx);
        st2_next.cuy  = mul_hi(st1_reg.sqy, st1_reg.ty);
        st2_next.cuz  = mul_hi(st1_reg.sqz, st1_reg.tz);
    end

    // stage 3: hash in z, smoothstep, corner pairs chosen by mode
    always_comb
    begin
        logic [7:0] aa, ab, ba, bb;
        aa = st2_reg.ra  + st2_reg.zi;
        ab = st2_reg.ra1 + st2_reg.zi;
        ba = st2_reg.rb  + st2_reg.zi;
        bb = st2_reg.rb1 + st2_reg.zi;
        st3_next.mode = st2_reg.mode;
        st3_next.u    = smooth_finish(st2_reg.sqx, st2_reg.cux);
        st3_next.v    = smooth_finish(st2_reg.sqy, st2_reg.cuy);
        st3_next.w    = smooth_finish(st2_reg.sqz, st2_reg.cuz);
        case (st2_reg.mode)
            MODE_1D:
            begin
                st3_next.lo = {24'd0, st2_reg.p0};
                st3_next.hi = {24'd0, st2_reg.p1};
            end
            MODE_2D:
            begin
                st3_next.lo = {16'd0, st2_reg.ra1, st2_reg.ra};
                st3_next.hi = {16'd0, st2_reg.rb1, st2_reg.rb};
            end
            default:
            begin
                st3_next.lo = {PERM_ROM[ab + 8'd1], PERM_ROM[aa + 8'd1],
                               PERM_ROM[ab], PERM_ROM[aa]};
                st3_next.hi = {PERM_ROM[bb + 8'd1], PERM_ROM[ba + 8'd1],
                               PERM_ROM[bb], PERM_ROM[ba]};
            end
        endcase
    end

    // stage 4: blends along x
    always_comb
    begin
        st4_next.mode = st3_reg.mode;
        st4_next.v    = st3_reg.v;
        st4_next.w    = st3_reg.w;
        for (int i = 0; i < 4; i++)
        begin
            st4_next.xb[i] = blend8(st3_reg.lo[i], st3_reg.hi[i], st3_reg.u);
        end
    end

    // stage 5: blends along y, 1-D passes straight on
    always_comb
    begin
        st5_next.mode = st4_reg.mode;
        st5_next.w    = st4_reg.w;
        if (st4_reg.mode == MODE_1D)
        begin
            st5_next.yb[0] = st4_reg.xb[0];
        end
        else
        begin
            st5_next.yb[0] = blend8(st4_reg.xb[0], st4_reg.xb[1], st4_reg.v);
        end
        st5_next.yb[1] = blend8(st4_reg.xb[2], st4_reg.xb[3], st4_reg.v);
    end

    // stage 6: blend along z for 3-D only
    always_comb
    begin
        if (st5_reg.mode == MODE_3D)
        begin
            out_next = blend8(st5_reg.yb[0], st5_reg.yb[1], st5_reg.w);
        end
        else
        begin
            out_next = st5_reg.yb[0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (eno) vo_reg <= v5_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (en1) st1_reg <= st1_next;
        if (en2) st2_reg <= st2_next;
        if (en3) st3_reg <= st3_next;
        if (en4) st4_reg <= st4_next;
        if (en5) st5_reg <= st5_next;
        if (eno) out_reg <= out_next;
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    // input can only be held off when the whole pipe is full and the output waits
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (vo_reg && v5_reg && v4_reg && v3_reg && v2_reg && v1_reg && !m_tready))
        else $error("input stalled with room in the pipe");

    // an accepted request lands in the first stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request lost at stage one");

    // a waiting result is never overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && !m_tready) |=> (vo_reg && out_reg == $past(out_reg)))
        else $error("pending result changed");

    // register write takes effect
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (dims_reg == $past(pwdata[1:0])))
        else $error("dimensions write not applied");
`endif

endmodule

`default_nettype wire
